[src/arps_pkg.sv]
// ----------------------------------------------------------------------------
// arps_pkg
// Shared types, widths and the power-curve table of the proximity scaler.
// ----------------------------------------------------------------------------
package arps_pkg;

  localparam int unsigned AVG_COUNT_DEF      = 10;
  localparam int unsigned NUM_ELECTRODES_DEF = 13;

  localparam int unsigned ELEC_W   = 4;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DIST_W   = 8;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned Y_W      = 17;
  localparam int unsigned SEG_W    = 6;
  localparam int unsigned HI_W     = FRAC_W + 1 - SEG_W;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [SAMPLE_W-1:0] MIN_START_RESET = SAMPLE_W'(400);
  localparam logic [CNT_W-1:0]    RATIO_STEPS     = CNT_W'(FRAC_W + 1);
  localparam logic [Y_W-1:0]      Y_ONE           = Y_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVERAGE,
    ST_UPDATE,
    ST_RATIO_WAIT,
    ST_CURVE,
    ST_OUTPUT
  } arps_state_e;

  typedef struct packed {
    logic accept;
    logic start_avg;
    logic average;
    logic update;
    logic curve;
    logic load_out;
  } arps_cmd_t;

  typedef struct packed {
    logic last;
    logic div_busy;
    logic out_busy;
  } arps_sts_t;

  function automatic logic [Y_W-1:0] curve_lut(input logic [HI_W-1:0] idx);
    logic [Y_W-1:0] v;
    unique case (idx)
      7'd0:  v = 17'd0;     7'd1:  v = 17'd16;    7'd2:  v = 17'd65;
      7'd3:  v = 17'd146;   7'd4:  v = 17'd259;   7'd5:  v = 17'd404;
      7'd6:  v = 17'd582;   7'd7:  v = 17'd792;   7'd8:  v = 17'd1034;
      7'd9:  v = 17'd1308;  7'd10: v = 17'd1614;  7'd11: v = 17'd1952;
      7'd12: v = 17'd2322;  7'd13: v = 17'd2724;  7'd14: v = 17'd3158;
      7'd15: v = 17'd3624;  7'd16: v = 17'd4122;  7'd17: v = 17'd4653;
      7'd18: v = 17'd5215;  7'd19: v = 17'd5809;  7'd20: v = 17'd6435;
      7'd21: v = 17'd7093;  7'd22: v = 17'd7783;  7'd23: v = 17'd8505;
      7'd24: v = 17'd9258;  7'd25: v = 17'd10044; 7'd26: v = 17'd10862;
      7'd27: v = 17'd11711; 7'd28: v = 17'd12593; 7'd29: v = 17'd13506;
      7'd30: v = 17'd14451; 7'd31: v = 17'd15428; 7'd32: v = 17'd16437;
      7'd33: v = 17'd17478; 7'd34: v = 17'd18551; 7'd35: v = 17'd19656;
      7'd36: v = 17'd20792; 7'd37: v = 17'd21960; 7'd38: v = 17'd23161;
      7'd39: v = 17'd24393; 7'd40: v = 17'd25657; 7'd41: v = 17'd26952;
      7'd42: v = 17'd28280; 7'd43: v = 17'd29639; 7'd44: v = 17'd31031;
      7'd45: v = 17'd32454; 7'd46: v = 17'd33909; 7'd47: v = 17'd35395;
      7'd48: v = 17'd36914; 7'd49: v = 17'd38464; 7'd50: v = 17'd40046;
      7'd51: v = 17'd41660; 7'd52: v = 17'd43306; 7'd53: v = 17'd44984;
      7'd54: v = 17'd46693; 7'd55: v = 17'd48434; 7'd56: v = 17'd50207;
      7'd57: v = 17'd52012; 7'd58: v = 17'd53849; 7'd59: v = 17'd55717;
      7'd60: v = 17'd57617; 7'd61: v = 17'd59549; 7'd62: v = 17'd61513;
      7'd63: v = 17'd63508;
      default: v = Y_ONE;
    endcase
    return v;
  endfunction

endpackage

[src/arps_div.sv]
// ----------------------------------------------------------------------------
// arps_div
// Restoring divider, one quotient bit per cycle, used for the range ratio.
// ----------------------------------------------------------------------------
module arps_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [arps_pkg::SAMPLE_W-1:0] rem_i,
  input  logic [arps_pkg::SUM_W-1:0]    dvd_i,
  input  logic [arps_pkg::CNT_W-1:0]    steps_i,
  input  logic [arps_pkg::SAMPLE_W-1:0] dvs_i,
  output logic                          busy_o,
  output logic [arps_pkg::SUM_W-1:0]    quo_o
);
  import arps_pkg::*;

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]    dvd_q, dvd_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [SAMPLE_W-1:0] dvs_q, dvs_d;
  logic [SAMPLE_W:0]   rem_sh;
  logic [SAMPLE_W:0]   rem_sub;
  logic                fits;

  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_i;
      dvd_d  = dvd_i;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
      dvd_d  = {dvd_q[SUM_W-2:0], 1'b0};
      quo_d  = {quo_q[SUM_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = cnt_q != CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[src/arps_datapath.sv]
// ----------------------------------------------------------------------------
// arps_datapath
// Group accumulator, per-electrode range registers, curve lookup and the
// output register.
// ----------------------------------------------------------------------------
module arps_datapath #(
  parameter int unsigned AVG_COUNT      = arps_pkg::AVG_COUNT_DEF,
  parameter int unsigned NUM_ELECTRODES = arps_pkg::NUM_ELECTRODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arps_pkg::arps_cmd_t           cmd_i,
  output arps_pkg::arps_sts_t           sts_o,
  input  logic [arps_pkg::ELEC_W-1:0]   elec_i,
  input  logic [arps_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          cfg_we_i,
  input  logic [arps_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [arps_pkg::ELEC_W-1:0]   out_elec_o,
  output logic [arps_pkg::SAMPLE_W-1:0] out_avg_o,
  output logic [arps_pkg::DIST_W-1:0]   out_dist_o
);
  import arps_pkg::*;

  localparam int unsigned IDX_W = (NUM_ELECTRODES > 1) ? $clog2(NUM_ELECTRODES) : 1;

  // floor(sum / AVG_COUNT) as (sum * ceil(2^AVG_SH / AVG_COUNT)) >> AVG_SH
  localparam int unsigned        AVG_SH    = SUM_W + $clog2(AVG_COUNT);
  localparam int unsigned        RECIP_W   = SUM_W + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << AVG_SH) + AVG_COUNT - 1) / AVG_COUNT);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    sum_add;
  logic [SUM_W-1:0]    grp_sum_q;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  logic [SAMPLE_W-1:0] min_q [NUM_ELECTRODES];
  logic [SAMPLE_W-1:0] rng_q [NUM_ELECTRODES];
  logic [ELEC_W-1:0]   elec_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic                zero_q;
  logic [Y_W-1:0]      y_q;
  logic                out_valid_q;
  logic [ELEC_W-1:0]   out_elec_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic [DIST_W-1:0]   out_dist_q;

  logic                elec_ok;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] cur_min, cur_rng, new_min, delta, new_rng;

  logic                div_start, div_busy;
  logic [SAMPLE_W-1:0] div_rem, div_dvs;
  logic [SUM_W-1:0]    div_dvd, div_quo;
  logic [CNT_W-1:0]    div_steps;

  logic [FRAC_W:0]        ratio;
  logic [HI_W-1:0]        hi;
  logic [SEG_W-1:0]       lo;
  logic [Y_W-1:0]         c0, c1, c_diff, y_w;
  logic [Y_W+SEG_W-1:0]   seg_prod;
  logic [Y_W+DIST_W-1:0]  scaled;

  assign sum_add = sum_q + SUM_W'(sample_i);

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (cmd_i.accept) begin
      if (sts_o.last) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_add;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  assign avg_prod = grp_sum_q * AVG_RECIP;

  assign elec_ok = {1'b0, elec_q} < (ELEC_W + 1)'(NUM_ELECTRODES);
  assign idx     = elec_ok ? elec_q[IDX_W-1:0] : '0;
  assign cur_min = min_q[idx];
  assign cur_rng = rng_q[idx];
  assign new_min = (avg_q < cur_min) ? avg_q : cur_min;
  assign delta   = avg_q - new_min;
  assign new_rng = (delta > cur_rng) ? delta : cur_rng;

  assign div_start = cmd_i.update;
  assign div_rem   = {1'b0, delta[SAMPLE_W-1:1]};
  assign div_dvd   = {delta[0], {(SUM_W-1){1'b0}}};
  assign div_steps = RATIO_STEPS;
  assign div_dvs   = new_rng;

  arps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .dvd_i   (div_dvd),
    .steps_i (div_steps),
    .dvs_i   (div_dvs),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign ratio    = div_quo[FRAC_W:0];
  assign hi       = ratio[FRAC_W:SEG_W];
  assign lo       = ratio[SEG_W-1:0];
  assign c0       = curve_lut(hi);
  assign c1       = curve_lut(hi + HI_W'(1));
  assign c_diff   = c1 - c0;
  assign seg_prod = c_diff * lo;
  assign y_w      = hi[HI_W-1] ? Y_ONE : c0 + seg_prod[Y_W+SEG_W-1:SEG_W];
  assign scaled   = {y_q, {DIST_W{1'b0}}} - (Y_W + DIST_W)'(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_ELECTRODES; i++) begin
        min_q[i] <= MIN_START_RESET;
        rng_q[i] <= '0;
      end
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        for (int i = 0; i < NUM_ELECTRODES; i++) begin
          min_q[i] <= cfg_wdata_i;
          rng_q[i] <= '0;
        end
      end else if (cmd_i.update && elec_ok) begin
        min_q[idx] <= new_min;
        rng_q[idx] <= new_rng;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elec_q <= elec_i;
    end
    if (cmd_i.start_avg) begin
      grp_sum_q <= sum_add;
    end
    if (cmd_i.average) begin
      avg_q <= avg_prod[AVG_SH +: SAMPLE_W];
    end
    if (cmd_i.update) begin
      zero_q <= !elec_ok || (new_rng == '0);
    end
    if (cmd_i.curve) begin
      y_q <= y_w;
    end
    if (cmd_i.load_out) begin
      out_elec_q <= elec_q;
      out_avg_q  <= avg_q;
      out_dist_q <= zero_q ? '0 : scaled[Y_W+DIST_W-2:Y_W-1];
    end
  end

  assign sts_o.last     = count_q == CNT_W'(AVG_COUNT - 1);
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_elec_o  = out_elec_q;
  assign out_avg_o   = out_avg_q;
  assign out_dist_o  = out_dist_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(AVG_COUNT))
    else $error("group count beyond group size");

  a_div_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("pending result overwritten");

endmodule

[src/arps_ctrl.sv]
// ----------------------------------------------------------------------------
// arps_ctrl
// Sequencer: accepts samples, walks a closed group through averaging,
// range update, ratio division, curve lookup and output.
// ----------------------------------------------------------------------------
module arps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arps_pkg::arps_sts_t sts_i,
  output arps_pkg::arps_cmd_t cmd_o
);
  import arps_pkg::*;

  arps_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.last) state_d = ST_AVERAGE;
      end
      ST_AVERAGE: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: begin
        if (!sts_i.div_busy) state_d = ST_CURVE;
      end
      ST_CURVE: begin
        state_d = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.accept    = in_valid_i;
        cmd_o.start_avg = in_valid_i && sts_i.last;
      end
      ST_AVERAGE: begin
        cmd_o.average = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      ST_CURVE: begin
        cmd_o.curve = 1'b1;
      end
      ST_OUTPUT: begin
        cmd_o.load_out = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_div_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.div_busy)
    else $error("divider busy while idle");

endmodule

[src/auto_ranging_proximity_scaler.sv]
// ----------------------------------------------------------------------------
// auto_ranging_proximity_scaler
// Averages electrode readings in groups and maps each group average to an
// auto-ranged, power-curved distance.
// ----------------------------------------------------------------------------
// A sample that does not close a group is accepted while the sequencer is
// idle. After the sample that closes a group (every AVG_COUNT-th),
// s_axis_tready_o stays low while the sequencer forms the average by
// reciprocal multiplication, updates the electrode's minimum and range,
// waits for the serial divider to finish the range ratio (13 steps), does
// the curve lookup and loads the output register, and also while the
// previous result still waits on m_axis_tready_i. Writing through cfg_we_i
// loads every running minimum and clears every range; the group in progress
// is kept. Distance is 0 while an electrode's range is zero and for
// electrode numbers at or above NUM_ELECTRODES.
// ----------------------------------------------------------------------------
module auto_ranging_proximity_scaler #(
  parameter int unsigned AVG_COUNT      = arps_pkg::AVG_COUNT_DEF,
  parameter int unsigned NUM_ELECTRODES = arps_pkg::NUM_ELECTRODES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // sample
  input  logic [arps_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // electrode
  input  logic [arps_pkg::ELEC_W-1:0]     s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // average, distance
  output logic [arps_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // electrode_out
  output logic [arps_pkg::ELEC_W-1:0]     m_axis_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [arps_pkg::SAMPLE_W-1:0]   cfg_wdata_i
);
  import arps_pkg::*;

  arps_cmd_t           cmd;
  arps_sts_t           sts;
  logic [SAMPLE_W-1:0] out_avg;
  logic [DIST_W-1:0]   out_dist;

  arps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arps_datapath #(
    .AVG_COUNT      (AVG_COUNT),
    .NUM_ELECTRODES (NUM_ELECTRODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .elec_i      (s_axis_tuser_i),
    .sample_i    (s_axis_tdata_i[SAMPLE_W-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_elec_o  (m_axis_tuser_o),
    .out_avg_o   (out_avg),
    .out_dist_o  (out_dist)
  );

  assign m_axis_tdata_o = {{(OUT_DATA_W - SAMPLE_W - DIST_W){1'b0}}, out_dist, out_avg};

endmodule
